### rtl/core/mtfs_pkg.sv
// Shared types and codes for the move-to-front identifier stack.
package mtfs_pkg;

   localparam int OPCODE_W = 2;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 2;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_OPEN   = 2'd0;
   localparam opcode_type OP_CLOSE  = 2'd1;
   localparam opcode_type OP_SWITCH = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   // Controller's datapath commands; one phase per cycle unless held.
   typedef struct packed {
      logic load;
      logic compare;
      logic select;
      logic update;
   } dp_cmd_type;

endpackage

### rtl/core/mtfs_ctrl.sv
// Controller state machine: sequences load, compare, select and update phases.
module mtfs_ctrl
   import mtfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_SELECT,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_SELECT;
         end
         S_SELECT: begin
            cmd.select = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            // hold until the output word is free
            if (slot_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_update_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || rsp_tready))
      else $error("update issued while output word still pending");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while one is in flight");
`endif

endmodule

### rtl/core/mtfs_datapath.sv
// Datapath: entry stack, parallel match, first-match select and shift update.
module mtfs_datapath
   import mtfs_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int ID_BITS     = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   input  opcode_type       req_opcode,
   input  logic [ID_W-1:0]  req_window_id,
   output status_type       rsp_status,
   output logic [ID_W-1:0]  rsp_echo_id,
   output logic             rsp_top_valid,
   output logic [ID_W-1:0]  rsp_top_id
);

   localparam int EW    = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

   logic [EW-1:0]          entries_ff [MAX_ENTRIES];
   logic [EW-1:0]          entries_in [MAX_ENTRIES];
   logic [EW-1:0]          shift_dn   [MAX_ENTRIES];
   logic [EW-1:0]          shift_up   [MAX_ENTRIES];
   logic [OCC_W-1:0]       occ_ff, occ_in;
   opcode_type             op_ff;
   logic [EW-1:0]          id_ff;
   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic [MAX_ENTRIES-1:0] onehot_ff;
   logic [MAX_ENTRIES-1:0] above;
   logic                   found;
   status_type             status_nx;

   status_type             status_ff;
   logic [ID_W-1:0]        echo_ff;
   logic                   top_valid_ff;
   logic [ID_W-1:0]        top_id_ff;

   assign rsp_status    = status_ff;
   assign rsp_echo_id   = echo_ff;
   assign rsp_top_valid = top_valid_ff;
   assign rsp_top_id    = top_id_ff;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_in[i] = (entries_ff[i] == id_ff) && (occ_ff > OCC_W'(i));
      end
   end

   // push-down and pull-up views of the stack
   always_comb begin
      shift_dn[0] = id_ff;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
         shift_dn[i] = entries_ff[i-1];
      end
      shift_up[MAX_ENTRIES-1] = entries_ff[MAX_ENTRIES-1];
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
         shift_up[i] = entries_ff[i+1];
      end
   end

   always_comb begin
      entries_in = entries_ff;
      occ_in     = occ_ff;
      status_nx  = ST_OK;
      // bits for entries nearer the top than the first match
      above      = onehot_ff - MAX_ENTRIES'(1);
      found      = |onehot_ff;
      if (cmd.update) begin
         case (op_ff)
            OP_OPEN: begin
               if (occ_ff == OCC_W'(MAX_ENTRIES)) begin
                  status_nx = ST_FULL;
               end else begin
                  entries_in = shift_dn;
                  occ_in     = occ_ff + OCC_W'(1);
               end
            end
            OP_CLOSE, OP_SWITCH: begin
               if (occ_ff == '0) begin
                  status_nx = ST_EMPTY;
               end else if (!found) begin
                  status_nx = ST_NOT_FOUND;
               end else if (op_ff == OP_CLOSE) begin
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (!above[i]) entries_in[i] = shift_up[i];
                  end
                  occ_in = occ_ff - OCC_W'(1);
               end else begin
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (above[i] || onehot_ff[i]) entries_in[i] = shift_dn[i];
                  end
               end
            end
            default: begin
               status_nx = ST_NOT_FOUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (cmd.load) begin
         op_ff <= req_opcode;
         id_ff <= req_window_id[EW-1:0];
      end
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (cmd.select) begin
         // isolate the match nearest the top
         onehot_ff <= match_ff & (~match_ff + MAX_ENTRIES'(1));
      end
      if (cmd.update) begin
         status_ff    <= status_nx;
         echo_ff      <= (status_nx == ST_OK) ? ID_W'(id_ff) : '0;
         top_valid_ff <= (occ_in != '0);
         top_id_ff    <= (occ_in != '0) ? ID_W'(entries_in[0]) : '0;
      end
   end

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(MAX_ENTRIES))
      else $error("occupancy above capacity");

   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.select |=> $onehot0(onehot_ff))
      else $error("first-match select not one-hot");

   a_occ_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(occ_ff))
      else $error("occupancy changed outside update phase");
`endif

endmodule

### rtl/core/move_to_front_id_stack_top.sv
// Flow: an accepted word is loaded, and its result is registered in the update phase.
// A new word is taken only in the idle state, so one word at a time passes the compare, first-match
// select and shift update phases of the controller.
// Stalls: the update phase holds while the previous result still waits on the output.
// Reset: synchronous, active high; clears occupancy and handshake state, while
// stack entries stay undefined until pushed and are never read before that.
module move_to_front_id_stack_top
   import mtfs_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // window_id[15:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // echo_id[15:0], top_valid[16], top_id[32:17], zero[39:33]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   dp_cmd_type      cmd;
   status_type      status;
   logic [ID_W-1:0] echo_id;
   logic            top_valid;
   logic [ID_W-1:0] top_id;

   mtfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mtfs_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req_tuser),
      .req_window_id (req_tdata),
      .rsp_status    (status),
      .rsp_echo_id   (echo_id),
      .rsp_top_valid (top_valid),
      .rsp_top_id    (top_id)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {7'd0, top_id, top_valid, echo_id};

endmodule

### dv/move_to_front_id_stack_top_tb.sv
// Self-checking bench for the move-to-front identifier stack: directed and random requests.
module move_to_front_id_stack_top_tb;
   import mtfs_pkg::*;

   localparam int MAX_ENTRIES = 16;
   localparam int ID_BITS     = 16;
   localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_BITS) - 1);
   localparam opcode_type OP_UNUSED = 2'd3;

   typedef struct packed {
      opcode_type  op;
      logic [15:0] id;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] echo_id;
      logic        top_valid;
      logic [15:0] top_id;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // window_id[15:0]
   logic [1:0]  req_tuser = '0;    // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // echo_id[15:0], top_valid[16], top_id[32:17], zero[39:33]
   logic [1:0]  rsp_tuser;         // status[1:0]

   move_to_front_id_stack_top #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .ID_BITS    (ID_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the recency stack; entry 0 is the top.
   logic [15:0] mtf_stack [MAX_ENTRIES];
   int          mtf_depth = 0;
   int          peak_depth = 0;

   req_item_type req_backlog [$];
   rsp_item_type expected_rsp_q [$];
   req_item_type req_cur;
   bit          req_pending = 0;
   int          send_gap = 0;
   int          rsp_stall = 0;
   bit          hold_off = 0;
   int          total_items = 0;
   int          req_sent = 0;
   int          rsp_seen = 0;
   int          error_count = 0;
   int          status_seen [4] = '{0, 0, 0, 0};

   function automatic rsp_item_type mtf_apply(req_item_type r);
      rsp_item_type o;
      logic [15:0] id;
      int          pos;
      int          i;
      id = r.id & ID_MASK;
      o.status = ST_OK;
      case (r.op)
         OP_OPEN: begin
            if (mtf_depth >= MAX_ENTRIES) begin
               o.status = ST_FULL;
            end else begin
               for (i = mtf_depth; i > 0; i--) mtf_stack[i] = mtf_stack[i-1];
               mtf_stack[0] = id;
               mtf_depth++;
            end
         end
         OP_CLOSE, OP_SWITCH: begin
            if (mtf_depth == 0) begin
               o.status = ST_EMPTY;
            end else begin
               // scan upward so the match nearest the top wins
               pos = mtf_depth;
               for (i = mtf_depth - 1; i >= 0; i--) if (mtf_stack[i] == id) pos = i;
               if (pos == mtf_depth) begin
                  o.status = ST_NOT_FOUND;
               end else if (r.op == OP_CLOSE) begin
                  for (i = pos; i + 1 < mtf_depth; i++) mtf_stack[i] = mtf_stack[i+1];
                  mtf_depth--;
               end else begin
                  for (i = pos; i > 0; i--) mtf_stack[i] = mtf_stack[i-1];
                  mtf_stack[0] = id;
               end
            end
         end
         default: o.status = ST_NOT_FOUND;
      endcase
      if (mtf_depth > peak_depth) peak_depth = mtf_depth;
      o.echo_id   = (o.status == ST_OK) ? id : 16'd0;
      o.top_valid = (mtf_depth > 0);
      o.top_id    = (mtf_depth > 0) ? mtf_stack[0] : 16'd0;
      return o;
   endfunction

   function automatic bit send_idle_ok();
      return (req_sent + 250 < total_items) && ((req_sent / 150) % 3 != 2);
   endfunction

   function automatic bit recv_idle_ok();
      return (rsp_seen + 250 < total_items) && ((rsp_seen / 130) % 3 != 1);
   endfunction

   task automatic add_req(opcode_type op, logic [15:0] id);
      req_item_type r;
      r.op = op;
      r.id = id;
      req_backlog.push_back(r);
   endtask

   // Sender: offer a new word once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_pending) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_cur = req_backlog.pop_front();
            req_pending = 1;
            req_tvalid <= 1'b1;
            req_tdata  <= req_cur.id;
            req_tuser  <= req_cur.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, plus the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (recv_idle_ok() && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      bit        bad;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(mtf_apply(req_cur));
            req_sent++;
            req_pending = 0;
            if (send_idle_ok() && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser;
            got.echo_id   = rsp_tdata[15:0];
            got.top_valid = rsp_tdata[16];
            got.top_id    = rsp_tdata[32:17];
            rsp_seen++;
            status_seen[got.status]++;
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected result status=%0d echo=%h top_valid=%0d top=%h",
                           got.status, got.echo_id, got.top_valid, got.top_id);
            end else begin
               want = expected_rsp_q.pop_front();
               bad = (got.status !== want.status) || (got.echo_id !== want.echo_id) ||
                     (got.top_valid !== want.top_valid) || (got.top_id !== want.top_id) ||
                     (rsp_tdata[39:33] !== 7'd0);
               if (bad) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"ERROR: result %0d exp status=%0d echo=%h tv=%0d top=%h,",
                               " got status=%0d echo=%h tv=%0d top=%h pad=%h"},
                              rsp_seen, want.status, want.echo_id, want.top_valid, want.top_id,
                              got.status, got.echo_id, got.top_valid, got.top_id,
                              rsp_tdata[39:33]);
               end
            end
         end
      end
   end

   // Long receiver hold-off so the block backs up into its input.
   initial begin
      wait (req_sent >= 600);
      @(posedge clock);
      hold_off = 1;
      repeat (300) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [15:0] id_pool [8];
      int          mode;
      int          pick;
      int          k;
      int          n;
      opcode_type  op;
      logic [15:0] id;

      // Directed: empty stack, unused opcode, duplicates, top switch, fill to capacity.
      add_req(OP_CLOSE,  16'h1234);
      add_req(OP_SWITCH, 16'h1234);
      add_req(OP_UNUSED, 16'hFFFF);
      add_req(OP_OPEN,   16'hFFFF);
      add_req(OP_OPEN,   16'h0000);
      add_req(OP_OPEN,   16'hFFFF);
      add_req(OP_SWITCH, 16'hFFFF);
      add_req(OP_SWITCH, 16'h0000);
      add_req(OP_CLOSE,  16'hFFFF);
      add_req(OP_CLOSE,  16'h5A5A);
      add_req(OP_UNUSED, 16'h0000);
      for (k = 0; k < MAX_ENTRIES - 2; k++) add_req(OP_OPEN, 16'(k * 16'h1111 + 16'h0101));
      add_req(OP_OPEN,   16'hA5A5);
      add_req(OP_SWITCH, 16'hFFFF);

      // Random: segments lean toward filling, draining or churning the stack.
      for (n = 0; n < 1725; n++) begin
         if (n % 40 == 0) begin
            mode = $urandom_range(0, 2);
            for (k = 0; k < 8; k++) id_pool[k] = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0) id_pool[0] = 16'h0000;
            if ($urandom_range(0, 3) == 0) id_pool[1] = 16'hFFFF;
         end
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            op = OP_UNUSED;
         end else begin
            pick = $urandom_range(0, 99);
            case (mode)
               0:       op = (pick < 65) ? OP_OPEN : (pick < 80) ? OP_CLOSE : OP_SWITCH;
               1:       op = (pick < 20) ? OP_OPEN : (pick < 75) ? OP_CLOSE : OP_SWITCH;
               default: op = (pick < 40) ? OP_OPEN : (pick < 65) ? OP_CLOSE : OP_SWITCH;
            endcase
         end
         if ($urandom_range(0, 9) == 0) id = 16'($urandom_range(0, 65535));
         else id = id_pool[$urandom_range(0, 7)];
         add_req(op, id);
      end
      total_items = req_backlog.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (req_sent == total_items && expected_rsp_q.size() == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d open/close/switch requests; stack peaked at %0d of %0d entries.",
               req_sent, peak_depth, MAX_ENTRIES);
      $display("Results: ok %0d, not found %0d, empty %0d, full %0d; %0d errors.",
               status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_EMPTY],
               status_seen[ST_FULL], error_count);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
